// ===== sv/crc32_frame_receiver_defines.svh =====
// assertion macros shared by the crc32 frame receiver modules
// no dependencies; modules that assert take this header by include
`ifndef CRC32_FRAME_RECEIVER_DEFINES_SVH
`define CRC32_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked on every edge outside reset, clocked by clock
`define CRCFR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("crcfr assertion failed");
// checked on every edge, reset included
`define CRCFR_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("crcfr assertion failed");
`else
`define CRCFR_ASSERT(lbl, prop)
`define CRCFR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== sv/crcfr_pkg.sv =====
// types, constants and the byte-wide crc-32 update of the frame receiver
// no dependencies; used by the parser, the checker and the top level
package crcfr_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
   localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;

   localparam logic [7:0] FIRST_HDR_RESET = 8'hAA;
   localparam logic [7:0] SECOND_HDR_RESET = 8'h55;

   // register indexes of the configuration port
   localparam logic [7:0] CSR_FIRST_HDR = 8'd0;
   localparam logic [7:0] CSR_SECOND_HDR = 8'd1;

   // header is two sync bytes, sequence (2) and length (1); trailer is the crc
   localparam logic [8:0] HEAD_LEN = 9'd5;
   localparam logic [8:0] FRAME_OVERHEAD = 9'd9;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD = 2'd1;
   localparam logic [1:0] KIND_BAD = 2'd2;

   // operations queued from the front to the back
   typedef enum logic [2:0] {
      OP_START,
      OP_BYTE,
      OP_PAYLOAD,
      OP_TRAILER,
      OP_LAST
   } crcfr_op_code_type;

   typedef struct packed {
      crcfr_op_code_type code;
      logic [7:0]        data;
      logic [7:0]        index;
      logic [15:0]       seq;
      logic [7:0]        len;
   } crcfr_op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [7:0]  index;
      logic [15:0] seq;
      logic [7:0]  len;
      logic [31:0] bad;
   } crcfr_rsp_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== sv/crcfr_fifo.sv =====
// small register-based fifo used for the operation queue and the result queue
// no package dependencies
module crcfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W:0]   rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   assign full = (wr_ptr_ff[PTR_W] != rd_ptr_ff[PTR_W])
              && (wr_ptr_ff[PTR_W-1:0] == rd_ptr_ff[PTR_W-1:0]);
   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign rdata = mem_ff[rd_ptr_ff[PTR_W-1:0]];

   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign wr_ptr_in = do_push ? wr_ptr_ff + {{PTR_W{1'b0}}, 1'b1} : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + {{PTR_W{1'b0}}, 1'b1} : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff[PTR_W-1:0]] <= wdata;
      end
   end

endmodule

// ===== sv/crcfr_front.sv =====
// frame parser: header hunt, sequence and length capture, byte classification
// depends on crcfr_pkg and crc32_frame_receiver_defines.svh
`include "crc32_frame_receiver_defines.svh"

module crcfr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [7:0]            csr_index,
   input  logic [7:0]            csr_data,
   output logic                  csr_ready,
   input  logic                  req_push,
   input  logic [7:0]            req_data_byte,
   input  logic                  op_full,
   output logic                  op_push,
   output crcfr_pkg::crcfr_op_type op
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HDR2,
      PH_FIELDS,
      PH_BODY
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [8:0]  pos_ff, pos_in;
   logic [15:0] seq_ff, seq_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  hdr1_ff, hdr1_in;
   logic [7:0]  hdr2_ff, hdr2_in;
   logic        accept;
   logic [7:0]  b;
   logic [8:0]  pay_end;
   logic [8:0]  pos_inc;

   assign csr_ready = 1'b1;
   assign accept = req_push && !op_full;
   assign b = req_data_byte;
   assign pay_end = crcfr_pkg::HEAD_LEN + {1'b0, len_ff};
   assign pos_inc = pos_ff + 9'd1;

   always_comb begin
      hdr1_in = hdr1_ff;
      hdr2_in = hdr2_ff;
      if (csr_valid) begin
         if (csr_index == crcfr_pkg::CSR_FIRST_HDR) begin
            hdr1_in = csr_data;
         end else if (csr_index == crcfr_pkg::CSR_SECOND_HDR) begin
            hdr2_in = csr_data;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      seq_in = seq_ff;
      len_in = len_ff;
      op_push = 1'b0;
      op.code = crcfr_pkg::OP_BYTE;
      op.data = b;
      op.index = '0;
      op.seq = seq_ff;
      op.len = len_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (b == hdr1_ff) begin
                  op_push = 1'b1;
                  op.code = crcfr_pkg::OP_START;
                  phase_in = PH_HDR2;
                  pos_in = 9'd1;
               end
            end
            PH_HDR2: begin
               priority if (b == hdr2_ff) begin
                  op_push = 1'b1;
                  op.code = crcfr_pkg::OP_BYTE;
                  phase_in = PH_FIELDS;
                  pos_in = 9'd2;
                  seq_in = '0;
                  len_in = '0;
               end else if (b == hdr1_ff) begin
                  op_push = 1'b1;
                  op.code = crcfr_pkg::OP_START;
                  pos_in = 9'd1;
               end else begin
                  phase_in = PH_HUNT;
                  pos_in = '0;
               end
            end
            PH_FIELDS: begin
               op_push = 1'b1;
               op.code = crcfr_pkg::OP_BYTE;
               pos_in = pos_inc;
               priority if (pos_ff == 9'd2) begin
                  seq_in = {8'd0, b};
               end else if (pos_ff == 9'd3) begin
                  seq_in = {b, seq_ff[7:0]};
               end else begin
                  len_in = b;
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               op_push = 1'b1;
               pos_in = pos_inc;
               priority if (pos_ff < pay_end) begin
                  op.code = crcfr_pkg::OP_PAYLOAD;
                  op.index = 8'(pos_ff - crcfr_pkg::HEAD_LEN);
               end else if (pos_inc == ({1'b0, len_ff} + crcfr_pkg::FRAME_OVERHEAD)) begin
                  op.code = crcfr_pkg::OP_LAST;
                  phase_in = PH_HUNT;
                  pos_in = '0;
               end else begin
                  op.code = crcfr_pkg::OP_TRAILER;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               pos_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff <= '0;
         seq_ff <= '0;
         len_ff <= '0;
         hdr1_ff <= crcfr_pkg::FIRST_HDR_RESET;
         hdr2_ff <= crcfr_pkg::SECOND_HDR_RESET;
      end else begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         seq_ff <= seq_in;
         len_ff <= len_in;
         hdr1_ff <= hdr1_in;
         hdr2_ff <= hdr2_in;
      end
   end

   // inside the body the position never runs past the end of the trailer
   `CRCFR_ASSERT(a_pos_in_frame,
      (phase_ff == PH_BODY) |-> (pos_ff < ({1'b0, len_ff} + crcfr_pkg::FRAME_OVERHEAD)))
   // while hunting only the first sync byte reaches the queue
   `CRCFR_ASSERT(a_hunt_push,
      (op_push && (phase_ff == PH_HUNT)) |-> (req_data_byte == hdr1_ff))

endmodule

// ===== sv/crcfr_back.sv =====
// frame checker: crc-32 accumulation, trailer capture, verdict and bad counter
// depends on crcfr_pkg and crc32_frame_receiver_defines.svh
`include "crc32_frame_receiver_defines.svh"

module crcfr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    op_empty,
   input  crcfr_pkg::crcfr_op_type op,
   output logic                    op_pop,
   input  logic                    rsp_full,
   output logic                    rsp_push,
   output crcfr_pkg::crcfr_rsp_type rsp
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] rx_ff, rx_in;
   logic [31:0] bad_ff, bad_in;
   logic [31:0] crc_upd;
   logic [31:0] rx_shift;
   logic        good;

   assign op_pop = !op_empty && !rsp_full;
   assign crc_upd = crcfr_pkg::crc_byte(
      (op.code == crcfr_pkg::OP_START) ? crcfr_pkg::CRC_INIT : crc_ff, op.data);
   assign rx_shift = {op.data, rx_ff[31:8]};
   assign good = (rx_shift == ~crc_ff);

   always_comb begin
      crc_in = crc_ff;
      rx_in = rx_ff;
      bad_in = bad_ff;
      rsp_push = 1'b0;
      rsp.kind = crcfr_pkg::KIND_PAYLOAD;
      rsp.data = op.data;
      rsp.index = op.index;
      rsp.seq = op.seq;
      rsp.len = op.len;
      rsp.bad = bad_ff;
      if (op_pop) begin
         unique case (op.code)
            crcfr_pkg::OP_START, crcfr_pkg::OP_BYTE: begin
               crc_in = crc_upd;
            end
            crcfr_pkg::OP_PAYLOAD: begin
               crc_in = crc_upd;
               rsp_push = 1'b1;
            end
            crcfr_pkg::OP_TRAILER: begin
               rx_in = rx_shift;
            end
            crcfr_pkg::OP_LAST: begin
               rx_in = rx_shift;
               rsp_push = 1'b1;
               rsp.data = '0;
               rsp.index = '0;
               if (good) begin
                  rsp.kind = crcfr_pkg::KIND_GOOD;
               end else begin
                  rsp.kind = crcfr_pkg::KIND_BAD;
                  if (bad_ff != crcfr_pkg::COUNT_MAX) begin
                     bad_in = bad_ff + 32'd1;
                  end
               end
               rsp.bad = bad_in;
            end
            default: begin
               crc_in = crc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= crcfr_pkg::CRC_INIT;
         rx_ff <= '0;
         bad_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         rx_ff <= rx_in;
         bad_ff <= bad_in;
      end
   end

   // the bad frame counter only ever moves up
   `CRCFR_ASSERT(a_bad_monotonic, !$past(reset) |-> (bad_ff >= $past(bad_ff)))
   // results are produced only when the result queue has room
   `CRCFR_ASSERT_ALWAYS(a_rsp_room, rsp_push |-> !rsp_full)

endmodule

// ===== sv/crc32_frame_receiver.sv =====
// crc32 frame receiver top level: parser, operation queue, checker, result queue
// depends on crcfr_pkg, crcfr_fifo, crcfr_front and crcfr_back
//
// usage
// - request channel: one received serial byte per request on req_data_byte,
//   taken at a clock edge with req_push high and req_full low
// - result channel: a result waits on the rsp_ ports while rsp_empty is low
//   and leaves at an edge with rsp_pop high; kind 0 is a payload byte with its
//   index, kind 1 a good frame, kind 2 a bad crc frame; sequence, length and
//   the bad frame count ride along with every result
// - configuration: csr_index 0 sets the first sync byte, 1 the second sync
//   byte, other indexes are dropped; csr_ready is always high, and a write
//   takes effect on the next request
// - throughput: one request per cycle while req_full is low; the crc update
//   is a byte-wide unrolled checker step, one byte per cycle unless rsp_full
// - path: a payload byte or verdict passes through the operation queue and
//   the checker into the result queue, whose registered head drives the ports
// - stalls: when the result side stops popping, the result queue and then the
//   operation queue fill, and req_full rises; no request is lost
// - reset: synchronous, active high; the parser goes back to hunting, sync
//   bytes return to 0xaa and 0x55, the bad count clears and both queues empty
module crc32_frame_receiver #(
   parameter int QUEUE_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // configuration port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data,
   // request channel
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   // result channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_data,
   output logic [7:0]  rsp_payload_index,
   output logic [15:0] rsp_sequence_number,
   output logic [7:0]  rsp_payload_length,
   output logic [31:0] rsp_bad_frames
);

   localparam int OP_W = $bits(crcfr_pkg::crcfr_op_type);
   localparam int RSP_W = $bits(crcfr_pkg::crcfr_rsp_type);

   // parser to operation queue
   crcfr_pkg::crcfr_op_type  op_wr;
   logic                     op_push;
   logic                     op_full;
   // operation queue to checker
   crcfr_pkg::crcfr_op_type  op_head;
   logic                     op_pop;
   logic                     op_empty;
   // checker to result queue
   crcfr_pkg::crcfr_rsp_type rsp_wr;
   crcfr_pkg::crcfr_rsp_type rsp_head;
   logic                     rsp_push;
   logic                     rsp_full;

   // the request side backs up only on the operation queue
   assign req_full = op_full;

   crcfr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .csr_ready     (csr_ready),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .op_full       (op_full),
      .op_push       (op_push),
      .op            (op_wr)
   );

   // decouples parsing from checking so either side can stall
   crcfr_fifo #(
      .WIDTH (OP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_op_queue (
      .clock (clock),
      .reset (reset),
      .push  (op_push),
      .wdata (op_wr),
      .full  (op_full),
      .pop   (op_pop),
      .rdata (op_head),
      .empty (op_empty)
   );

   crcfr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_empty (op_empty),
      .op       (op_head),
      .op_pop   (op_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp      (rsp_wr)
   );

   // result queue: registered output, lets the checker run while a result waits
   crcfr_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_head),
      .empty (rsp_empty)
   );

   assign rsp_kind = rsp_head.kind;
   assign rsp_payload_data = rsp_head.data;
   assign rsp_payload_index = rsp_head.index;
   assign rsp_sequence_number = rsp_head.seq;
   assign rsp_payload_length = rsp_head.len;
   assign rsp_bad_frames = rsp_head.bad;

endmodule
